[src/assert_macros.svh]
// Assertion helpers for the RTL file that checks its own logic.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CPL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define CPL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpl_pkg.sv]
package cpl_pkg;

  // Archive layout constants of the newc format.
  localparam int HEADER_BYTES  = 110;
  localparam int OFS_FILE_SIZE = 54;
  localparam int OFS_NAME_SIZE = 94;
  localparam int HEX_DIGITS    = 8;
  localparam int MAX_NAME      = 24;
  localparam int TARGET_CAP    = 24;
  localparam int TRAILER_LEN   = 10;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TGT_LOW  = 3'd0;
  localparam logic [2:0] CFG_TGT_MID  = 3'd1;
  localparam logic [2:0] CFG_TGT_HIGH = 3'd2;
  localparam logic [2:0] CFG_TGT_LEN  = 3'd3;
  localparam logic [2:0] CFG_LOAD     = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FOUND     = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_SKIP,
    PH_SKIP_PAD,
    PH_LOAD
  } phase_e;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] write_address;
    logic [31:0] file_size;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [63:0] target_chars_low;
    logic [63:0] target_chars_mid;
    logic [63:0] target_chars_high;
    logic [4:0]  target_length;
    logic [31:0] load_base;
  } cfg_t;

  // Value of one ASCII hex digit; anything else counts as zero.
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Characters of the name that closes every archive.
  function automatic logic [7:0] trailer_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;  // T
      4'd1:    c = 8'h52;  // R
      4'd2:    c = 8'h41;  // A
      4'd3:    c = 8'h49;  // I
      4'd4:    c = 8'h4C;  // L
      4'd5:    c = 8'h45;  // E
      4'd6:    c = 8'h52;  // R
      4'd7:    c = 8'h21;  // !
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/cpl_in_reg.sv]
module cpl_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cpl_pkg::item_t in_item_i,
  input  logic          take_i,
  output logic          vld_o,
  output cpl_pkg::item_t item_o
);

  logic           vld_q;
  cpl_pkg::item_t item_q;

  // The register takes a new beat when it is empty or being drained.
  assign in_stall_o = vld_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[src/cpl_scan.sv]
module cpl_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cpl_pkg::item_t   item_i,
  input  cpl_pkg::cfg_t    cfg_i,
  output logic             res_vld_o,
  output cpl_pkg::result_t res_o
);

  localparam logic [1:0] HdrMod4 = 2'(cpl_pkg::HEADER_BYTES % 4);

  cpl_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] fsize_q, fsize_d;
  logic [31:0] nsize_q, nsize_d;
  logic        name_ok_q, name_ok_d;
  logic        trl_ok_q, trl_ok_d;

  cpl_pkg::phase_e eff_phase;
  logic [31:0] eff_pos;
  logic [31:0] pos_inc;
  logic [31:0] name_len;
  logic [1:0]  name_pad;
  logic [1:0]  data_pad;
  logic        do_decide;
  logic [7:0]  b;

  // Target character at a name position below the target capacity.
  function automatic logic [7:0] tgt_char(cpl_pkg::cfg_t c, logic [4:0] idx);
    logic [63:0] w;
    case (idx[4:3])
      2'd0:    w = c.target_chars_low;
      2'd1:    w = c.target_chars_mid;
      2'd2:    w = c.target_chars_high;
      default: w = 64'd0;
    endcase
    w = w >> {idx[2:0], 3'b000};
    return w[7:0];
  endfunction

  assign b = item_i.archive_byte;

  // A first byte restarts the walk at header offset zero.
  assign eff_phase = item_i.first_byte ? cpl_pkg::PH_HEADER : phase_q;
  assign eff_pos   = item_i.first_byte ? 32'd0 : pos_q;
  assign pos_inc   = eff_pos + 32'd1;

  // Padding to the next 4-byte boundary after the name and after the data.
  assign name_pad = 2'd0 - (HdrMod4 + nsize_q[1:0]);
  assign data_pad = 2'd0 - fsize_q[1:0];

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    fsize_d   = fsize_q;
    nsize_d   = nsize_q;
    name_ok_d = name_ok_q;
    trl_ok_d  = trl_ok_q;
    do_decide = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;
    name_len  = 32'd0;

    case (eff_phase)
      cpl_pkg::PH_HEADER: begin
        if (eff_pos == 32'd0) begin
          fsize_d = 32'd0;
          nsize_d = 32'd0;
        end
        if (eff_pos >= 32'(cpl_pkg::OFS_FILE_SIZE) &&
            eff_pos < 32'(cpl_pkg::OFS_FILE_SIZE + cpl_pkg::HEX_DIGITS)) begin
          fsize_d = {fsize_d[27:0], cpl_pkg::hex_value(b)};
        end
        if (eff_pos >= 32'(cpl_pkg::OFS_NAME_SIZE) &&
            eff_pos < 32'(cpl_pkg::OFS_NAME_SIZE + cpl_pkg::HEX_DIGITS)) begin
          nsize_d = {nsize_d[27:0], cpl_pkg::hex_value(b)};
        end
        pos_d   = pos_inc;
        phase_d = cpl_pkg::PH_HEADER;
        if (pos_inc >= 32'(cpl_pkg::HEADER_BYTES)) begin
          name_len  = (nsize_d == 32'd0) ? 32'd0 : nsize_d - 32'd1;
          pos_d     = 32'd0;
          name_ok_d = (name_len == {27'd0, cfg_i.target_length}) &&
                      (name_len <= 32'(cpl_pkg::MAX_NAME)) &&
                      (cfg_i.target_length <= 5'(cpl_pkg::TARGET_CAP));
          trl_ok_d  = name_len == 32'(cpl_pkg::TRAILER_LEN);
          phase_d   = (nsize_d == 32'd0) ? cpl_pkg::PH_NAME_PAD : cpl_pkg::PH_NAME;
        end
      end

      cpl_pkg::PH_NAME: begin
        // Compare every name byte but the closing NUL.
        if (pos_inc < nsize_q) begin
          if (eff_pos >= 32'(cpl_pkg::TARGET_CAP) ||
              b != tgt_char(cfg_i, eff_pos[4:0])) begin
            name_ok_d = 1'b0;
          end
          if (eff_pos >= 32'(cpl_pkg::TRAILER_LEN) ||
              b != cpl_pkg::trailer_char(eff_pos[3:0])) begin
            trl_ok_d = 1'b0;
          end
        end
        pos_d = pos_inc;
        if (pos_inc >= nsize_q) begin
          pos_d = 32'd0;
          if (name_pad == 2'd0) begin
            do_decide = 1'b1;
          end else begin
            phase_d = cpl_pkg::PH_NAME_PAD;
          end
        end
      end

      cpl_pkg::PH_NAME_PAD: begin
        pos_d = pos_inc;
        if (pos_inc >= {30'd0, name_pad}) begin
          do_decide = 1'b1;
        end
      end

      cpl_pkg::PH_SKIP: begin
        pos_d = pos_inc;
        if (pos_inc >= fsize_q) begin
          pos_d   = 32'd0;
          phase_d = (data_pad == 2'd0) ? cpl_pkg::PH_HEADER : cpl_pkg::PH_SKIP_PAD;
        end
      end

      cpl_pkg::PH_SKIP_PAD: begin
        pos_d = pos_inc;
        if (pos_inc >= {30'd0, data_pad}) begin
          pos_d   = 32'd0;
          phase_d = cpl_pkg::PH_HEADER;
        end
      end

      cpl_pkg::PH_LOAD: begin
        res_vld_o           = 1'b1;
        res_o.kind          = cpl_pkg::KIND_DATA;
        res_o.data_byte     = b;
        res_o.write_address = cfg_i.load_base + eff_pos;
        res_o.last          = pos_inc >= fsize_q;
        pos_d               = pos_inc;
        if (pos_inc >= fsize_q) begin
          pos_d   = 32'd0;
          phase_d = cpl_pkg::PH_IDLE;
        end
      end

      default: begin
        // Idle: bytes are dropped until the next first byte.
      end
    endcase

    // The whole name region is consumed: trailer test first, then the target.
    if (do_decide) begin
      pos_d = 32'd0;
      if (trl_ok_d) begin
        res_vld_o  = 1'b1;
        res_o.kind = cpl_pkg::KIND_NOT_FOUND;
        res_o.last = 1'b1;
        phase_d    = cpl_pkg::PH_IDLE;
      end else if (name_ok_d) begin
        res_vld_o           = 1'b1;
        res_o.kind          = cpl_pkg::KIND_FOUND;
        res_o.write_address = cfg_i.load_base;
        res_o.file_size     = fsize_q;
        res_o.last          = fsize_q == 32'd0;
        phase_d = (fsize_q == 32'd0) ? cpl_pkg::PH_IDLE : cpl_pkg::PH_LOAD;
      end else begin
        phase_d = (fsize_q == 32'd0) ? cpl_pkg::PH_HEADER : cpl_pkg::PH_SKIP;
      end
    end
  end

  // Walk state advances once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cpl_pkg::PH_IDLE;
      pos_q     <= 32'd0;
      fsize_q   <= 32'd0;
      nsize_q   <= 32'd0;
      name_ok_q <= 1'b1;
      trl_ok_q  <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      fsize_q   <= fsize_d;
      nsize_q   <= nsize_d;
      name_ok_q <= name_ok_d;
      trl_ok_q  <= trl_ok_d;
    end
  end

endmodule

[src/cpl_out_reg.sv]
module cpl_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cpl_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpl_pkg::result_t out_item_o
);

  logic             vld_q;
  cpl_pkg::result_t res_q;

  // Room for a new result when empty or when the held beat leaves now.
  assign free_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = res_q;

endmodule

[src/cpio_newc_file_locator.sv]
// Finds one member of a cpio newc archive streamed in one byte per beat and
// unloads it. Each accepted byte is taken into an input register and then
// handled in a single registered pass, so the block sustains one archive byte
// per clock cycle; a byte's result is loaded into the result register when
// the byte is processed from the input register. A result reports the target
// found (with its size), each data byte of the target with its load address,
// or the trailer reached without a match; the final result of a search
// carries last. A byte marked first_byte restarts the scan from header offset
// zero at any time, and bytes after the final result of a search are dropped
// until then. A held byte is only processed while the result register is
// free, so throughput stays at one byte per cycle only while the result side
// keeps up. Configuration must be written while idle; this is not enforced.
`include "assert_macros.svh"

module cpio_newc_file_locator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpl_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpl_pkg::result_t out_item_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_wdata_i
);

  cpl_pkg::cfg_t    cfg_q;
  cpl_pkg::item_t   item;
  cpl_pkg::result_t res;
  logic             item_vld;
  logic             res_vld;
  logic             out_free;
  logic             step;
  logic             out_not_found;
  logic             out_found;
  logic             not_found_ok;
  logic             found_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpl_pkg::CFG_TGT_LOW:  cfg_q.target_chars_low  <= cfg_wdata_i;
        cpl_pkg::CFG_TGT_MID:  cfg_q.target_chars_mid  <= cfg_wdata_i;
        cpl_pkg::CFG_TGT_HIGH: cfg_q.target_chars_high <= cfg_wdata_i;
        cpl_pkg::CFG_TGT_LEN:  cfg_q.target_length     <= cfg_wdata_i[4:0];
        cpl_pkg::CFG_LOAD:     cfg_q.load_base         <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // A held byte is processed when the result register can take its outcome.
  assign step = item_vld && out_free;

  cpl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (step),
    .vld_o      (item_vld),
    .item_o     (item)
  );

  cpl_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  cpl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_vld),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Terms of the result encoding checks.
  assign out_not_found = out_valid_o && (out_item_o.kind == cpl_pkg::KIND_NOT_FOUND);
  assign out_found     = out_valid_o && (out_item_o.kind == cpl_pkg::KIND_FOUND);
  assign not_found_ok  = out_item_o.last && (out_item_o.file_size == 32'd0);
  assign found_ok      = out_item_o.last == (out_item_o.file_size == 32'd0);

  // Checks on the pipeline and the result encoding.
  `CPL_ASSERT(a_stall_needs_item, in_stall_o |-> item_vld, "stall without a held beat")
  `CPL_ASSERT_NEXT(a_result_lands, step && res_vld, out_valid_o, "result beat lost")
  `CPL_ASSERT(a_not_found_last, out_not_found |-> not_found_ok, "bad not-found beat")
  `CPL_ASSERT(a_found_last, out_found |-> found_ok, "found beat last mismatch")

endmodule
